[rtl/ddo_pkg.sv]
// ----------------------------------------------------------------------------
// ddo_pkg: shared types, constants and helpers of the odometry block
// Payload layouts, fixed-point constants, arctangent table and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

   // default parameter values
   localparam int POSE_WIDTH_DEF   = 32;
   localparam int CORDIC_STEPS_DEF = 16;

   // configuration register indexes
   localparam logic REG_WHEEL_RADIUS = 1'b0;
   localparam logic REG_WHEEL_BASE   = 1'b1;

   localparam logic [15:0] RADIUS_RESET = 16'd3277;
   localparam logic [15:0] BASE_RESET   = 16'd4915;

   // serial divider geometry
   localparam int DIV_W = 64;
   localparam int REM_W = 16;

   // pose accumulator width (covers the widest pose plus one guard bit)
   localparam int SUM_W = 49;

   // CORDIC datapath width, Q1.30 plus guard bits
   localparam int CORDIC_W = 34;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;

   // angles in Q3.13
   localparam logic signed [17:0] PI_Q13      = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
   localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
   localparam logic signed [15:0] PI_Q13_16   = 16'sd25736;

   // constant divisors
   localparam logic [REM_W-1:0] DIV_HEADING = 16'd8000;
   localparam logic [REM_W-1:0] DIV_MS      = 16'd1000;
   localparam logic [REM_W-1:0] DIV_TWO_PI  = 16'd51472;

   localparam logic [15:0] DT_MAX = 16'hFFFF;

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic [31:0]        time_ms;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] heading;
      logic signed [31:0] lin_vel;
      logic signed [31:0] ang_vel;
      logic [31:0]        out_time_ms;
   } rsp_type;

   // arctangent of 2^-i in Q1.30
   function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CORDIC_W-1:0] a;
      unique case (idx)
         5'd0:    a = 34'sh0_3243_F6A8;
         5'd1:    a = 34'sh0_1DAC_6705;
         5'd2:    a = 34'sh0_0FAD_BAFC;
         5'd3:    a = 34'sh0_07F5_6EA6;
         5'd4:    a = 34'sh0_03FE_AB76;
         5'd5:    a = 34'sh0_01FF_D55B;
         5'd6:    a = 34'sh0_00FF_FAAA;
         5'd7:    a = 34'sh0_007F_FF55;
         5'd8:    a = 34'sh0_003F_FFEA;
         5'd9:    a = 34'sh0_001F_FFFD;
         5'd10:   a = 34'sh0_000F_FFFF;
         5'd11:   a = 34'sh0_0007_FFFF;
         5'd12:   a = 34'sh0_0003_FFFF;
         5'd13:   a = 34'sh0_0001_FFFF;
         5'd14:   a = 34'sh0_0000_FFFF;
         5'd15:   a = 34'sh0_0000_7FFF;
         5'd16:   a = 34'sh0_0000_3FFF;
         5'd17:   a = 34'sh0_0000_1FFF;
         5'd18:   a = 34'sh0_0000_0FFF;
         5'd19:   a = 34'sh0_0000_07FF;
         5'd20:   a = 34'sh0_0000_03FF;
         5'd21:   a = 34'sh0_0000_01FF;
         5'd22:   a = 34'sh0_0000_00FF;
         5'd23:   a = 34'sh0_0000_007F;
         default: a = '0;
      endcase
      return a;
   endfunction

   // fold a signed remainder of a division by 2*pi into (-pi, pi]
   function automatic logic signed [15:0] wrap_q13(input logic [REM_W-1:0] rem,
                                                   input logic neg);
      logic signed [17:0] m;
      m = neg ? -$signed({2'b00, rem}) : $signed({2'b00, rem});
      if (m > PI_Q13) begin
         m = m - TWO_PI_Q13;
      end else if (m <= -PI_Q13) begin
         m = m + TWO_PI_Q13;
      end
      return m[15:0];
   endfunction

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [31:0] r;
      if (v[SUM_W-1:31] == '0 || v[SUM_W-1:31] == '1) begin
         r = v[31:0];
      end else begin
         r = v[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/ddo_stream_if.sv]
// ----------------------------------------------------------------------------
// ddo_stream_if: valid/ready channel
// Carries one payload word per transfer between a source and a sink.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddo_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/differential_drive_odometry.sv]
// ----------------------------------------------------------------------------
// differential_drive_odometry: wheel odometry with midpoint heading
// Integrates a planar pose from left and right wheel speed samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one item per transfer: cmd, left_speed, right_speed and
//   time_ms. A sample (cmd 0) yields one item on rsp_chan with the pose,
//   heading, velocities and the echoed time. cmd 1 zeroes the pose, re-arms
//   the first-sample flag and yields nothing.
//   The first sample after reset or cmd 1 goes straight to the output stage.
//   Any other sample makes six passes through the shared bit-serial
//   divider (angular rate, heading step, two heading folds, x and y
//   steps), with the product set-up states S_P and S_PLO before each axis
//   step and the CORDIC running beside the last fold.
//   One item is worked on at a time; req_chan.ready is high only when idle.
//   A finished result waits in the output register; if the receiver stalls,
//   the next sample is accepted and worked on, then holds until that
//   register is free.
//   csr_write_en writes the wheel radius (index 0) or the wheel base
//   (index 1); write only while idle. Reset restores the register defaults,
//   zeroes the pose and arms the first-sample flag.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry #(
   parameter int POSE_WIDTH   = ddo_pkg::POSE_WIDTH_DEF,
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ddo_stream_if.sink   req_chan,
   ddo_stream_if.source rsp_chan,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data
);
   localparam int DW = ddo_pkg::DIV_W;
   localparam int RW = ddo_pkg::REM_W;
   localparam int SW = ddo_pkg::SUM_W;
   localparam int CW = ddo_pkg::CORDIC_W;

   typedef enum logic [3:0] {
      S_IDLE, S_LIN, S_ANG, S_DTH0, S_DTH, S_WM0, S_WM, S_WH0, S_WH,
      S_P, S_PLO, S_PHI, S_PDIV, S_OUT
   } state_type;

   state_type state_ff;

   logic                   first_ff;
   logic [31:0]            prev_time_ff;
   logic [15:0]            radius_ff;
   logic [15:0]            base_ff;
   logic signed [POSE_WIDTH-1:0] pose_x_ff;
   logic signed [POSE_WIDTH-1:0] pose_y_ff;
   logic signed [15:0]     heading_ff;

   logic signed [15:0]     left_ff;
   logic signed [15:0]     right_ff;
   logic [31:0]            time_ff;
   logic [15:0]            dt_ff;
   logic signed [24:0]     lin_ff;
   logic signed [31:0]     ang_ff;
   logic                   neg_ff;
   logic signed [37:0]     a_mid_ff;
   logic signed [37:0]     a_head_ff;
   logic signed [15:0]     mid_ff;
   logic signed [15:0]     head_new_ff;
   logic                   axis_ff;
   logic [41:0]            pmag_ff;
   logic [38:0]            plo_ff;

   logic                   rsp_valid_ff;
   ddo_pkg::rsp_type       rsp_payload_ff;

   // datapath nets
   logic [31:0]            du;
   logic [15:0]            dt_new;
   logic signed [16:0]     sum_lr;
   logic signed [16:0]     diff_rl;
   logic signed [33:0]     lin_prod;
   logic signed [33:0]     num_prod;
   logic [33:0]            num_mag;
   logic [31:0]            ang_mag;
   logic signed [DW:0]     qs;
   logic signed [31:0]     ang_sat;
   logic signed [37:0]     dth;
   logic signed [37:0]     dth_adj;
   logic signed [37:0]     half;
   logic [37:0]            amid_mag;
   logic [37:0]            ahead_mag;
   logic signed [CW-1:0]   trig;
   logic signed [CW+24:0]  p_prod;
   logic signed [44:0]     p_val;
   logic [44:0]            p_mag;
   logic [34:0]            phi;
   logic [57:0]            pd_sum;
   logic signed [SW-1:0]   delta;
   logic signed [SW-1:0]   pose_cur;
   logic signed [SW-1:0]   pose_sum;
   logic signed [POSE_WIDTH-1:0] pose_sat;

   logic                   div_start;
   logic [DW-1:0]          div_dividend;
   logic [RW-1:0]          div_divisor;
   logic                   div_busy;
   logic [DW-1:0]          div_quo;
   logic [RW-1:0]          div_rem;

   logic                   cor_start;
   logic                   cor_busy;
   logic signed [CW-1:0]   cor_cos;
   logic signed [CW-1:0]   cor_sin;

   logic                   req_xfer;
   logic                   out_free;

   ddo_sdiv u_sdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   ddo_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (mid_ff),
      .busy    (cor_busy),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // time step, wheel sums and products
   always_comb begin
      du = req_chan.payload.time_ms - prev_time_ff;
      if (du[31] || du == 32'd0) begin
         dt_new = 16'd1;
      end else if (du > 32'(ddo_pkg::DT_MAX)) begin
         dt_new = ddo_pkg::DT_MAX;
      end else begin
         dt_new = du[15:0];
      end

      sum_lr   = 17'(left_ff) + 17'(right_ff);
      diff_rl  = 17'(right_ff) - 17'(left_ff);
      lin_prod = 34'(sum_lr) * $signed({18'b0, radius_ff});
      num_prod = 34'(diff_rl) * $signed({18'b0, radius_ff});
      num_mag  = num_prod[33] ? 34'(-num_prod) : 34'(num_prod);
      ang_mag  = ang_ff[31] ? 32'(-ang_ff) : 32'(ang_ff);

      // signed quotient and its 32-bit clamp
      qs = neg_ff ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      if (qs[DW:31] == '0 || qs[DW:31] == '1) begin
         ang_sat = qs[31:0];
      end else begin
         ang_sat = qs[DW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end

      // heading step and midpoint angle before folding
      dth       = qs[37:0];
      dth_adj   = dth + $signed({37'b0, dth[37]});
      half      = dth_adj >>> 1;
      amid_mag  = a_mid_ff[37] ? 38'(-a_mid_ff) : 38'(a_mid_ff);
      ahead_mag = a_head_ff[37] ? 38'(-a_head_ff) : 38'(a_head_ff);

      // motion step along the selected axis
      trig   = axis_ff ? cor_sin : cor_cos;
      p_prod = (CW+25)'(lin_ff) * (CW+25)'(trig);
      p_val  = p_prod[58:14];
      p_mag  = p_val[44] ? 45'(-p_val) : 45'(p_val);
      phi    = 35'(pmag_ff[41:23]) * 35'(dt_ff);
      pd_sum = {phi, 23'b0} + 58'(plo_ff);

      delta    = qs[DW:16];
      pose_cur = axis_ff ? SW'(pose_y_ff) : SW'(pose_x_ff);
      pose_sum = pose_cur + delta;
      if (pose_sum[SW-1:POSE_WIDTH-1] == '0 || pose_sum[SW-1:POSE_WIDTH-1] == '1) begin
         pose_sat = pose_sum[POSE_WIDTH-1:0];
      end else begin
         pose_sat = pose_sum[SW-1] ? {1'b1, {(POSE_WIDTH-1){1'b0}}}
                                   : {1'b0, {(POSE_WIDTH-1){1'b1}}};
      end
   end

   // feed the divider and the CORDIC from the issuing state
   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      cor_start    = 1'b0;
      unique case (state_ff)
         S_LIN: begin
            div_start    = 1'b1;
            div_dividend = DW'({num_mag, 6'b0});
            div_divisor  = (base_ff == 16'd0) ? 16'd1 : base_ff;
         end
         S_DTH0: begin
            div_start    = 1'b1;
            div_dividend = DW'(48'(ang_mag) * 48'(dt_ff));
            div_divisor  = ddo_pkg::DIV_HEADING;
         end
         S_WM0: begin
            div_start    = 1'b1;
            div_dividend = DW'(amid_mag);
            div_divisor  = ddo_pkg::DIV_TWO_PI;
         end
         S_WH0: begin
            div_start    = 1'b1;
            div_dividend = DW'(ahead_mag);
            div_divisor  = ddo_pkg::DIV_TWO_PI;
            cor_start    = 1'b1;
         end
         S_PHI: begin
            div_start    = 1'b1;
            div_dividend = DW'(pd_sum);
            div_divisor  = ddo_pkg::DIV_MS;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // sequencer, pose state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= 1'b1;
         prev_time_ff <= '0;
         radius_ff    <= ddo_pkg::RADIUS_RESET;
         base_ff      <= ddo_pkg::BASE_RESET;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop a taken result unless a new one is loaded this cycle
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write_en) begin
            unique case (csr_index)
               ddo_pkg::REG_WHEEL_RADIUS: radius_ff <= csr_write_data;
               ddo_pkg::REG_WHEEL_BASE:   base_ff   <= csr_write_data;
               default:                   radius_ff <= radius_ff;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  left_ff  <= req_chan.payload.left_speed;
                  right_ff <= req_chan.payload.right_speed;
                  time_ff  <= req_chan.payload.time_ms;
                  dt_ff    <= dt_new;
                  if (req_chan.payload.cmd) begin
                     pose_x_ff  <= '0;
                     pose_y_ff  <= '0;
                     heading_ff <= '0;
                     first_ff   <= 1'b1;
                  end else if (first_ff) begin
                     first_ff     <= 1'b0;
                     prev_time_ff <= req_chan.payload.time_ms;
                     lin_ff       <= '0;
                     ang_ff       <= '0;
                     state_ff     <= S_OUT;
                  end else begin
                     prev_time_ff <= req_chan.payload.time_ms;
                     state_ff     <= S_LIN;
                  end
               end
            end
            S_LIN: begin
               lin_ff   <= lin_prod[33:9];
               neg_ff   <= num_prod[33];
               state_ff <= S_ANG;
            end
            S_ANG: begin
               if (!div_busy) begin
                  ang_ff   <= ang_sat;
                  state_ff <= S_DTH0;
               end
            end
            S_DTH0: begin
               neg_ff   <= ang_ff[31];
               state_ff <= S_DTH;
            end
            S_DTH: begin
               if (!div_busy) begin
                  a_mid_ff  <= 38'(heading_ff) + half;
                  a_head_ff <= 38'(heading_ff) + dth;
                  state_ff  <= S_WM0;
               end
            end
            S_WM0: begin
               neg_ff   <= a_mid_ff[37];
               state_ff <= S_WM;
            end
            S_WM: begin
               if (!div_busy) begin
                  mid_ff   <= ddo_pkg::wrap_q13(div_rem, neg_ff);
                  state_ff <= S_WH0;
               end
            end
            S_WH0: begin
               neg_ff   <= a_head_ff[37];
               state_ff <= S_WH;
            end
            S_WH: begin
               if (!div_busy && !cor_busy) begin
                  head_new_ff <= ddo_pkg::wrap_q13(div_rem, neg_ff);
                  axis_ff     <= 1'b0;
                  state_ff    <= S_P;
               end
            end
            S_P: begin
               pmag_ff  <= p_mag[41:0];
               neg_ff   <= p_val[44];
               state_ff <= S_PLO;
            end
            S_PLO: begin
               plo_ff   <= 39'(pmag_ff[22:0]) * 39'(dt_ff);
               state_ff <= S_PHI;
            end
            S_PHI: begin
               state_ff <= S_PDIV;
            end
            S_PDIV: begin
               if (!div_busy) begin
                  if (!axis_ff) begin
                     pose_x_ff <= pose_sat;
                     axis_ff   <= 1'b1;
                     state_ff  <= S_P;
                  end else begin
                     pose_y_ff  <= pose_sat;
                     heading_ff <= head_new_ff;
                     state_ff   <= S_OUT;
                  end
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_payload_ff.pos_x        <= ddo_pkg::sat32(SW'(pose_x_ff));
                  rsp_payload_ff.pos_y        <= ddo_pkg::sat32(SW'(pose_y_ff));
                  rsp_payload_ff.heading      <= heading_ff;
                  rsp_payload_ff.lin_vel      <= 32'(lin_ff);
                  rsp_payload_ff.ang_vel      <= ang_ff;
                  rsp_payload_ff.out_time_ms  <= time_ff;
                  state_ff                    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // stored heading stays folded into (-pi, pi]
   assert property (@(posedge clock) disable iff (reset)
      (heading_ff > -ddo_pkg::PI_Q13_16) && (heading_ff <= ddo_pkg::PI_Q13_16))
      else $error("heading out of range");

   // a pose reset command clears the pose and re-arms the first sample
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_chan.payload.cmd) |=>
         (pose_x_ff == '0 && pose_y_ff == '0 && heading_ff == '0 && first_ff))
      else $error("pose reset command not applied");

   // the divider is never restarted mid-division
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

endmodule

`default_nettype wire

[rtl/ddo_sdiv.sv]
// ----------------------------------------------------------------------------
// ddo_sdiv: bit-serial restoring divider
// Unsigned dividend by a 16-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_sdiv (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [ddo_pkg::DIV_W-1:0]  dividend,
   input  wire logic [ddo_pkg::REM_W-1:0]  divisor,
   output logic                            busy,
   output logic [ddo_pkg::DIV_W-1:0]       quotient,
   output logic [ddo_pkg::REM_W-1:0]       remainder
);
   localparam int DW = ddo_pkg::DIV_W;
   localparam int RW = ddo_pkg::REM_W;
   localparam int CW = $clog2(DW);

   logic [DW-1:0] quo_ff;
   logic [RW-1:0] rem_ff;
   logic [RW-1:0] dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;

   logic [RW:0]   trial;
   logic [RW:0]   diff;
   logic          fits;

   // trial subtract of the next dividend bit
   always_comb begin
      trial = {rem_ff, quo_ff[DW-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   // shift one quotient bit in per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DW-2:0], fits};
         rem_ff <= fits ? diff[RW-1:0] : trial[RW-1:0];
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // a finished division leaves a remainder below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && $past(busy_ff) && !$past(start)) |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

[rtl/ddo_cordic.sv]
// ----------------------------------------------------------------------------
// ddo_cordic: iterative rotation-mode CORDIC
// Cosine and sine in Q1.30 of a Q3.13 angle in (-pi, pi], one step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_cordic #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [15:0]                  angle,
   output logic                                     busy,
   output logic signed [ddo_pkg::CORDIC_W-1:0]      cos_out,
   output logic signed [ddo_pkg::CORDIC_W-1:0]      sin_out
);
   localparam int W  = ddo_pkg::CORDIC_W;
   localparam int IW = $clog2(CORDIC_STEPS);

   logic signed [W-1:0] x_ff;
   logic signed [W-1:0] y_ff;
   logic signed [W-1:0] z_ff;
   logic [IW-1:0]       iter_ff;
   logic                neg_ff;
   logic                busy_ff;

   logic signed [15:0]  a_adj;
   logic                a_neg;
   logic signed [W-1:0] xs;
   logic signed [W-1:0] ys;
   logic signed [W-1:0] at;

   // turn angles beyond a right angle by pi
   always_comb begin
      a_adj = angle;
      a_neg = 1'b0;
      if (angle > ddo_pkg::HALF_PI_Q13) begin
         a_adj = angle - ddo_pkg::PI_Q13_16;
         a_neg = 1'b1;
      end else if (angle < -ddo_pkg::HALF_PI_Q13) begin
         a_adj = angle + ddo_pkg::PI_Q13_16;
         a_neg = 1'b1;
      end
      xs = x_ff >>> iter_ff;
      ys = y_ff >>> iter_ff;
      at = ddo_pkg::atan_q30(5'(iter_ff));
   end

   // one micro-rotation per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         iter_ff <= '0;
         x_ff    <= ddo_pkg::CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= W'(a_adj) <<< 17;
         neg_ff  <= a_neg;
      end else if (busy_ff) begin
         if (!z_ff[W-1]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end
         iter_ff <= iter_ff + 1'b1;
         if (iter_ff == IW'(CORDIC_STEPS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy    = busy_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;

endmodule

`default_nettype wire

[tb/odometry_checker.sv]
// ----------------------------------------------------------------------------
// odometry_checker: pose prediction and result comparison
// Watches the sample, result and register ports of the odometry block. It
// integrates its own pose from every accepted sample and compares each
// returned result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module odometry_checker
   import ddo_pkg::*;
#(
   parameter int POSE_BITS = POSE_WIDTH_DEF,
   parameter int TRIG_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  req_type          req_payload,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  rsp_type          rsp_payload,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data,
   output int               failures,
   output int               pending,
   output int               results_seen
);

   localparam longint ANGLE_PI     = 25736;
   localparam longint ANGLE_2PI    = 51472;
   localparam longint ANGLE_HALFPI = 12868;
   localparam longint TRIG_GAIN    = 64'h26DD3B6A;
   localparam longint POSE_MAX     = (64'sd1 <<< (POSE_BITS - 1)) - 1;
   localparam longint POSE_MIN     = -POSE_MAX - 1;
   localparam longint WORD_MAX     = 64'sd2147483647;
   localparam longint WORD_MIN     = -64'sd2147483648;

   // arctangent of 2^-i, Q1.30
   localparam longint ARCTAN [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

   longint      radius_q16;
   longint      base_q14;
   longint      pose_x_q16;
   longint      pose_y_q16;
   longint      heading_q13;
   bit          awaiting_first;
   logic [31:0] last_stamp;
   rsp_type     pose_reports[$];

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // reduce an angle into (-pi, pi]
   function automatic longint fold_angle(input longint a);
      longint m;
      m = a % ANGLE_2PI;
      if (m > ANGLE_PI) m = m - ANGLE_2PI;
      if (m <= -ANGLE_PI) m = m + ANGLE_2PI;
      return m;
   endfunction

   // rotation-mode CORDIC, returns cosine and sine in Q1.30
   task automatic rotate(input longint a, output longint c, output longint s);
      longint x, y, z, nx;
      bit     flip;
      x = TRIG_GAIN;
      y = 0;
      flip = 0;
      if (a > ANGLE_HALFPI) begin
         a = a - ANGLE_PI;
         flip = 1;
      end else if (a < -ANGLE_HALFPI) begin
         a = a + ANGLE_PI;
         flip = 1;
      end
      z = a * 131072;
      for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - ARCTAN[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + ARCTAN[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint travel(input longint lin, input longint trig, input longint dt);
      longint p;
      p = (lin * trig) >>> 14;
      return ((p * dt) / 1000) >>> 16;
   endfunction

   // advance the pose by one sample and form its report
   task automatic integrate(input req_type q, output rsp_type rep);
      longint      lin, ang, dt, dth, mid, c, s, div;
      logic [31:0] step;
      lin = 0;
      ang = 0;
      if (awaiting_first) begin
         awaiting_first = 0;
      end else begin
         step = q.time_ms - last_stamp;
         dt = longint'($signed(step));
         if (dt <= 0) dt = 1;
         if (dt > 65535) dt = 65535;
         div = base_q14 != 0 ? base_q14 : 1;
         lin = (longint'(q.left_speed) + longint'(q.right_speed)) * radius_q16 >>> 9;
         ang = (longint'(q.right_speed) - longint'(q.left_speed)) * radius_q16 * 64 / div;
         ang = clamp(ang, WORD_MIN, WORD_MAX);
         dth = (ang * dt) / 8000;
         mid = fold_angle(heading_q13 + dth / 2);
         rotate(mid, c, s);
         pose_x_q16 = clamp(pose_x_q16 + travel(lin, c, dt), POSE_MIN, POSE_MAX);
         pose_y_q16 = clamp(pose_y_q16 + travel(lin, s, dt), POSE_MIN, POSE_MAX);
         heading_q13 = fold_angle(heading_q13 + dth);
      end
      last_stamp = q.time_ms;
      rep.pos_x       = 32'(clamp(pose_x_q16, WORD_MIN, WORD_MAX));
      rep.pos_y       = 32'(clamp(pose_y_q16, WORD_MIN, WORD_MAX));
      rep.heading     = heading_q13[15:0];
      rep.lin_vel     = 32'(clamp(lin, WORD_MIN, WORD_MAX));
      rep.ang_vel     = ang[31:0];
      rep.out_time_ms = q.time_ms;
   endtask

   task automatic compare(input string field, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endtask

   initial begin
      failures = 0;
      pending = 0;
      results_seen = 0;
   end

   always @(posedge clock) begin
      rsp_type rep;
      rsp_type want;
      if (reset) begin
         radius_q16 = longint'(RADIUS_RESET);
         base_q14 = longint'(BASE_RESET);
         pose_x_q16 = 0;
         pose_y_q16 = 0;
         heading_q13 = 0;
         awaiting_first = 1;
         last_stamp = '0;
         pose_reports.delete();
      end else begin
         // check the result transfer against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pose_reports.size() == 0) begin
               $error("result with no prediction waiting, time %0d",
                      rsp_payload.out_time_ms);
               failures++;
            end else begin
               want = pose_reports.pop_front();
               compare("pos_x", want.pos_x, rsp_payload.pos_x);
               compare("pos_y", want.pos_y, rsp_payload.pos_y);
               compare("heading", want.heading, rsp_payload.heading);
               compare("lin_vel", want.lin_vel, rsp_payload.lin_vel);
               compare("ang_vel", want.ang_vel, rsp_payload.ang_vel);
               compare("out_time_ms", want.out_time_ms, rsp_payload.out_time_ms);
            end
         end
         // predict from the sample transfer
         if (req_valid && req_ready) begin
            if (req_payload.cmd) begin
               pose_x_q16 = 0;
               pose_y_q16 = 0;
               heading_q13 = 0;
               awaiting_first = 1;
            end else begin
               integrate(req_payload, rep);
               pose_reports.push_back(rep);
            end
         end
         if (csr_write_en) begin
            if (csr_index == REG_WHEEL_RADIUS) radius_q16 = longint'(csr_write_data);
            else base_q14 = longint'(csr_write_data);
         end
      end
      pending = pose_reports.size();
   end

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: odometry block stimulus and verdict
// Drives directed and random wheel samples under several wheel geometries,
// with random gaps on the sample side and random stalls on the result side.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import ddo_pkg::*;

   localparam int CYCLE_LIMIT = 10000000;
   localparam int SETTLE      = 600;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic        csr_index;
   logic [15:0] csr_write_data;
   int          failures;
   int          pending;
   int          results_seen;
   int          samples_sent;
   int          pose_clears;
   int          cycle_count;
   int          stall_left;
   logic [31:0] stamp;

   ddo_stream_if #(.payload_type(req_type)) req_chan ();
   ddo_stream_if #(.payload_type(rsp_type)) rsp_chan ();

   differential_drive_odometry dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   odometry_checker watcher (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .req_payload(req_chan.payload),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .rsp_payload(rsp_chan.payload),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .failures(failures), .pending(pending), .results_seen(results_seen)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // hard stop on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: random stalls, mostly short, a few long, some stretches open
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         if ($urandom_range(0, 99) < 30) begin
            stall_left <= $urandom_range(0, 99) < 90 ? $urandom_range(1, 6)
                                                     : $urandom_range(50, 900);
         end
      end
   end

   // hold the sample line idle for a random gap
   task automatic idle_gap();
      int gap;
      gap = $urandom_range(0, 99);
      if (gap < 40) gap = 0;
      else if (gap < 92) gap = $urandom_range(1, 5);
      else gap = $urandom_range(30, 600);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // present one item and hold it until the transfer
   task automatic send(input logic cmd, input logic [15:0] l, input logic [15:0] r,
                       input logic [31:0] t);
      idle_gap();
      req_chan.valid <= 1'b1;
      req_chan.payload <= '{cmd, l, r, t};
      do @(posedge clock); while (!req_chan.ready);
      if (cmd) pose_clears++;
      else samples_sent++;
   endtask

   // wait, away from the clock edge, until every prediction has its result
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // advance the timestamp: mostly short steps, some zero, backward or huge
   task automatic next_stamp();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) stamp = stamp + $urandom_range(1, 200);
      else if (pick < 82) stamp = stamp;
      else if (pick < 88) stamp = stamp - $urandom_range(1, 5000);
      else if (pick < 94) stamp = stamp + $urandom_range(65000, 300000);
      else stamp = $urandom;
   endtask

   task automatic random_phase(input int count);
      logic [15:0] l, r;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 4) begin
            send(1'b1, 16'($urandom), 16'($urandom), $urandom);
         end else begin
            next_stamp();
            if ($urandom_range(0, 99) < 70) begin
               l = 16'($signed($urandom_range(0, 4000)) - 2000);
               r = l + 16'($signed($urandom_range(0, 600)) - 300);
            end else begin
               l = 16'($urandom);
               r = 16'($urandom);
            end
            send(1'b0, l, r, stamp);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      cycle_count = 0;
      samples_sent = 0;
      pose_clears = 0;
      csr_write_en = 1'b0;
      csr_index = REG_WHEEL_RADIUS;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      stamp = 32'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first sample, extreme speeds, odd time steps, pose clear
      send(1'b0, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF);
      send(1'b0, 16'h7FFF, 16'h7FFF, 32'd9);
      send(1'b0, 16'h8000, 16'h8000, 32'd9);
      send(1'b0, 16'h8000, 16'h7FFF, 32'd4);
      send(1'b0, 16'h7FFF, 16'h8000, 32'h0002_0000);
      send(1'b0, 16'h0000, 16'h0000, 32'h8002_0000);
      send(1'b0, 16'h0100, 16'h0100, 32'h8002_FFFF);
      send(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send(1'b0, 16'h0100, 16'h0200, 32'h0000_1000);
      for (int k = 0; k < 8; k++) begin
         stamp = 32'h0000_1000 + 32'(k + 1) * 32'd900;
         send(1'b0, 16'hF000, 16'h1000, stamp);
      end
      drain();

      // wide wheels on a narrow base: saturated turn rate, fast spin
      write_reg(REG_WHEEL_RADIUS, 16'hFFFF);
      write_reg(REG_WHEEL_BASE, 16'h0001);
      random_phase(200);
      // sender holds until every result is back
      drain();

      write_reg(REG_WHEEL_RADIUS, 16'h0001);
      write_reg(REG_WHEEL_BASE, 16'hFFFF);
      random_phase(150);
      drain();

      // zero base counts as one
      write_reg(REG_WHEEL_BASE, 16'h0000);
      write_reg(REG_WHEEL_RADIUS, 16'h8000);
      random_phase(150);
      drain();

      write_reg(REG_WHEEL_RADIUS, 16'($urandom_range(1, 65535)));
      write_reg(REG_WHEEL_BASE, 16'($urandom_range(1, 65535)));
      random_phase(150);
      drain();

      write_reg(REG_WHEEL_RADIUS, RADIUS_RESET);
      write_reg(REG_WHEEL_BASE, BASE_RESET);
      random_phase(150);
      drain();

      $display("covered %0d samples and %0d pose clears, %0d results checked",
               samples_sent, pose_clears, results_seen);
      $display("register settings: default, both extremes, zero base, random");
      if (failures == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
